/* src/utf8d_pkg.sv */
// Shared types, status codes and lead-byte decode for the UTF-8 decoder.
package utf8d_pkg;

  localparam int unsigned CP_W = 21;

  typedef logic [CP_W-1:0] cp_t;
  typedef logic [1:0]      status_t;
  typedef logic [7:0]      text_byte_t;

  localparam status_t ST_CHAR     = 2'd0;
  localparam status_t ST_BAD_LEAD = 2'd1;
  localparam status_t ST_BAD_CONT = 2'd2;
  localparam status_t ST_END      = 2'd3;

  typedef struct packed {
    cp_t     code_point;
    status_t status;
    logic    last;
  } result_t;

  // One queue entry: one or two results caused by a single byte.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

  typedef struct packed {
    logic       emit;
    result_t    res;
    logic       opens;
    cp_t        partial;
    logic [1:0] left;
  } lead_t;

  function automatic lead_t decode_lead(text_byte_t b);
    lead_t r;
    r = '0;
    r.res.last = 1'b1;
    if (b == 8'h00) begin
      r.emit = 1'b1;
      r.res.status = ST_END;
    end else if (!b[7]) begin
      r.emit = 1'b1;
      r.res.status = ST_CHAR;
      r.res.code_point = {13'b0, b};
    end else if (b[7:5] == 3'b110) begin
      r.opens = 1'b1;
      r.partial = {10'b0, b[4:0], 6'b0};
      r.left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      r.opens = 1'b1;
      r.partial = {5'b0, b[3:0], 12'b0};
      r.left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      r.opens = 1'b1;
      r.partial = {b[2:0], 18'b0};
      r.left = 2'd3;
    end else begin
      r.emit = 1'b1;
      r.res.status = ST_BAD_LEAD;
    end
    return r;
  endfunction

endpackage

/* src/utf8d_if.sv */
// Valid/ready channel interfaces for text bytes and decoded results.
interface utf8d_text_if;
  logic                  valid;
  logic                  ready;
  utf8d_pkg::text_byte_t text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface utf8d_code_if;
  logic               valid;
  logic               ready;
  utf8d_pkg::cp_t     code_point;
  utf8d_pkg::status_t status;
  logic               last;

  modport source (output valid, output code_point, output status, output last, input ready);
  modport sink (input valid, input code_point, input status, input last, output ready);
endinterface

/* src/utf8d_front.sv */
// Front end: accepts text bytes, tracks the open form and builds result entries.
module utf8d_front (
  input  logic              clk,
  input  logic              rst,
  utf8d_text_if.sink        text,
  input  logic              full,
  output logic              push,
  output utf8d_pkg::entry_t push_entry
);
  import utf8d_pkg::*;

  cp_t        partial;
  logic [1:0] left;
  cp_t        partial_next;
  logic [1:0] left_next;
  cp_t        cont_bits;
  cp_t        merged;
  lead_t      lead;
  logic       take;

  assign text.ready = !full;
  assign take = text.valid && text.ready;
  assign lead = decode_lead(text.text_byte);

  always_comb begin
    unique case (left)
      2'd3:    cont_bits = {3'b0, text.text_byte[5:0], 12'b0};
      2'd2:    cont_bits = {9'b0, text.text_byte[5:0], 6'b0};
      2'd1:    cont_bits = {15'b0, text.text_byte[5:0]};
      default: cont_bits = '0;
    endcase
  end

  assign merged = partial | cont_bits;

  always_comb begin
    partial_next = partial;
    left_next = left;
    push = 1'b0;
    push_entry = '0;
    if (take) begin
      if (left == 2'd0) begin
        push = lead.emit;
        push_entry.first = lead.res;
        if (lead.opens) begin
          partial_next = lead.partial;
          left_next = lead.left;
        end
      end else if (text.text_byte[7:6] == 2'b10) begin
        if (left == 2'd1) begin
          push = 1'b1;
          push_entry.first.code_point = merged;
          push_entry.first.status = ST_CHAR;
          push_entry.first.last = 1'b1;
          partial_next = '0;
          left_next = 2'd0;
        end else begin
          partial_next = merged;
          left_next = left - 2'd1;
        end
      end else begin
        // Report the broken form, then decode this byte again as a lead.
        push = 1'b1;
        push_entry.first.status = ST_BAD_CONT;
        push_entry.first.last = !lead.emit;
        push_entry.two = lead.emit;
        push_entry.second = lead.res;
        partial_next = lead.opens ? lead.partial : '0;
        left_next = lead.opens ? lead.left : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      left <= 2'd0;
    end else begin
      partial <= partial_next;
      left <= left_next;
    end
  end

endmodule

/* src/utf8d_fifo.sv */
// Two-entry queue of result entries between the front and back ends.
module utf8d_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  utf8d_pkg::entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output utf8d_pkg::entry_t head
);
  import utf8d_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/utf8d_back.sv */
// Back end: unpacks queue entries and drives the registered result channel.
module utf8d_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              empty,
  input  utf8d_pkg::entry_t head,
  output logic              pop,
  utf8d_code_if.source      code
);
  import utf8d_pkg::*;

  logic    out_valid;
  result_t out_res;
  logic    second;
  logic    load;
  result_t pick;

  assign load = !empty && (!out_valid || code.ready);
  assign pick = second ? head.second : head.first;
  // Drop the entry once its final result moves to the output register.
  assign pop = load && (second || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second <= head.two && !second;
      end else if (code.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= pick;
    end
  end

  assign code.valid = out_valid;
  assign code.code_point = out_res.code_point;
  assign code.status = out_res.status;
  assign code.last = out_res.last;

endmodule

/* src/utf8_byte_stream_decoder.sv */
// Top level of the UTF-8 byte stream decoder.
// Usage:
//   text carries one raw byte per item; code carries decoded results with
//   code_point, status (character, invalid lead, bad continuation, end of
//   text) and last, which marks the final result caused by one input byte.
//   A byte yields zero, one or two results; lead bytes of multi-byte forms
//   and inner continuation bytes yield none.
// Timing:
//   After its byte is accepted, a result passes the queue and then the
//   output register: the front end decodes and queues when the byte is
//   accepted, and the back end loads the output register once it is free.
//   One byte per cycle is taken while the output side keeps up; a byte that
//   gives two results occupies the single output register for each in turn.
// Stalls:
//   When code.ready is low the output register holds, the two-entry queue
//   fills and text.ready drops once it is full.
// Reset:
//   rst clears the open form, empties the queue and drops code.valid.
module utf8_byte_stream_decoder (
  input  logic         clk,
  input  logic         rst,
  utf8d_text_if.sink   text,
  utf8d_code_if.source code
);
  import utf8d_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t head;

  utf8d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .full       (full),
    .push       (push),
    .push_entry (push_entry)
  );

  utf8d_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  utf8d_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .code  (code)
  );

endmodule
